/* hdl/fibp_pkg.sv */
`default_nettype none

package fibp_pkg;

    // Input item: one command with its image byte.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_item;

    // Result item: one per accepted input item.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] block_address;
        logic [31:0] page_base;
        logic [7:0]  staged_byte;
        logic [7:0]  staged_offset;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_EOF     = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        KIND_HEADER_BYTE = 4'd0,
        KIND_ADDR_BYTE   = 4'd1,
        KIND_DATA_STAGED = 4'd2,
        KIND_WRITE       = 4'd3,
        KIND_ERASE_WRITE = 4'd4,
        KIND_BAD_HEADER  = 4'd5,
        KIND_MISALIGNED  = 4'd6,
        KIND_RANGE       = 4'd7,
        KIND_EOF_OK      = 4'd8,
        KIND_EOF_BAD     = 4'd9,
        KIND_REFUSED     = 4'd10,
        KIND_RESTARTED   = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BLOCK  = 3'b010,
        PH_ERROR  = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  byte_count;
        logic        header_mismatch;
        logic [31:0] assembled_address;
        logic [31:0] last_page;
        logic        last_page_valid;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:             PH_HEADER,
        byte_count:        8'd0,
        header_mismatch:   1'b0,
        assembled_address: 32'd0,
        last_page:         32'd0,
        last_page_valid:   1'b0
    };

    // Register indexes on the configuration port.
    localparam logic REG_MIN_ADDRESS = 1'b0;
    localparam logic REG_MAX_ADDRESS = 1'b1;

    localparam logic [31:0] ALIGN_MASK     = 32'h0000_007F;
    localparam logic [7:0]  ADDR_PAD_BYTES = 8'd8;

    // Header signature; bytes past the eighth are expected zero.
    localparam logic [7:0] SIGNATURE [16] = '{
        8'h49, 8'h4F, 8'h49, 8'h4F, 8'h01, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

/* hdl/fibp_step.sv */
`default_nettype none

module fibp_step #(
    parameter int BLOCK_BYTES      = 196,
    parameter int HEADER_BYTES     = 8,
    parameter int PAGE_OFFSET_BITS = 10
) (
    input  wire fibp_pkg::t_state    i_state,
    input  wire fibp_pkg::t_in_item  i_item,
    input  wire logic [31:0]         i_min_address,
    input  wire logic [31:0]         i_max_address,
    output fibp_pkg::t_state         o_state,
    output fibp_pkg::t_out_item      o_result
);
    import fibp_pkg::*;

    localparam logic [31:0] PAGE_MASK =
        ~((32'd1 << PAGE_OFFSET_BITS) - 32'd1);
    localparam logic [7:0] HDR_LEN = 8'(HEADER_BYTES);
    localparam logic [7:0] BLK_LEN = 8'(BLOCK_BYTES);

    logic [7:0]  cnt_inc;
    logic        hdr_bad;
    logic [31:0] addr;
    logic [31:0] page;
    logic [7:0]  data_offset;
    logic        misaligned;
    logic        out_of_range;
    logic        new_page;

    assign cnt_inc      = i_state.byte_count + 8'd1;
    assign hdr_bad      = i_state.header_mismatch |
                          (i_item.data_byte != SIGNATURE[i_state.byte_count[3:0]]);
    assign addr         = i_state.assembled_address;
    assign page         = addr & PAGE_MASK;
    assign data_offset  = i_state.byte_count - ADDR_PAD_BYTES;
    assign misaligned   = (addr & ALIGN_MASK) != 32'd0;
    assign out_of_range = (addr < i_min_address) || (addr >= i_max_address);
    assign new_page     = !i_state.last_page_valid || (page != i_state.last_page);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.command)
            CMD_BYTE: begin
                case (i_state.phase)
                    PH_HEADER: begin
                        o_state.header_mismatch = hdr_bad;
                        o_state.byte_count      = cnt_inc;
                        o_result.kind           = KIND_HEADER_BYTE;
                        if (cnt_inc >= HDR_LEN) begin
                            o_state.byte_count = 8'd0;
                            if (hdr_bad) begin
                                o_state.phase = PH_ERROR;
                                o_result.kind = KIND_BAD_HEADER;
                            end else begin
                                o_state.phase = PH_BLOCK;
                            end
                        end
                    end
                    PH_BLOCK: begin
                        o_state.byte_count = cnt_inc;
                        if (i_state.byte_count < 8'd4) begin
                            case (i_state.byte_count[1:0])
                                2'd0: o_state.assembled_address =
                                    {24'd0, i_item.data_byte};
                                2'd1: o_state.assembled_address =
                                    {addr[31:16], i_item.data_byte, addr[7:0]};
                                2'd2: o_state.assembled_address =
                                    {addr[31:24], i_item.data_byte, addr[15:0]};
                                default: o_state.assembled_address =
                                    {i_item.data_byte, addr[23:0]};
                            endcase
                        end
                        if (i_state.byte_count < ADDR_PAD_BYTES) begin
                            o_result.kind = KIND_ADDR_BYTE;
                        end else begin
                            o_result.staged_byte   = i_item.data_byte;
                            o_result.staged_offset = data_offset;
                            if (cnt_inc < BLK_LEN) begin
                                o_result.kind = KIND_DATA_STAGED;
                            end else begin
                                // Block complete: check and report.
                                o_state.byte_count     = 8'd0;
                                o_result.block_address = addr;
                                if (misaligned) begin
                                    o_state.phase = PH_ERROR;
                                    o_result.kind = KIND_MISALIGNED;
                                end else if (out_of_range) begin
                                    o_state.phase = PH_ERROR;
                                    o_result.kind = KIND_RANGE;
                                end else begin
                                    o_result.page_base = page;
                                    if (new_page) begin
                                        o_state.last_page       = page;
                                        o_state.last_page_valid = 1'b1;
                                        o_result.kind = KIND_ERASE_WRITE;
                                    end else begin
                                        o_result.kind = KIND_WRITE;
                                    end
                                end
                            end
                        end
                    end
                    default: o_result.kind = KIND_REFUSED;
                endcase
            end
            CMD_EOF: begin
                if (i_state.phase == PH_BLOCK && i_state.byte_count == 8'd0) begin
                    o_result.kind = KIND_EOF_OK;
                end else begin
                    o_result.kind = KIND_EOF_BAD;
                end
            end
            CMD_RESTART: begin
                o_state       = STATE_RESET;
                o_result.kind = KIND_RESTARTED;
            end
            default: o_result.kind = KIND_REFUSED;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/firmware_image_block_parser_top.sv */
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready   i_in_item  (command, data_byte)
// output    out        o_out_valid / i_out_ready o_out_item (kind, addresses, staged)
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// Every item is decoded combinationally against the parser state, and its
// result lands in the output register at the edge that accepts the item.
// One item per cycle is sustained while results drain; the only limit is the output register.
// An item is taken whenever the output register is empty or being drained,
// so a stalled consumer blocks input only while a result is left waiting.
// Reset is synchronous, active low: parser state back to the header phase,
// min_address to 0, max_address to all ones, output register empty.

module firmware_image_block_parser_top #(
    parameter int BLOCK_BYTES      = 196,
    parameter int HEADER_BYTES     = 8,
    parameter int PAGE_OFFSET_BITS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fibp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fibp_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);
    import fibp_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    t_out_item r_out_item;
    logic      r_out_valid;
    logic [31:0] r_min_address;
    logic [31:0] r_max_address;
    logic      in_take;

    // Take an item when the output register is free or drains this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_take    = i_in_valid && o_in_ready;

    fibp_step #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .HEADER_BYTES     (HEADER_BYTES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_step (
        .i_state       (r_state),
        .i_item        (i_in_item),
        .i_min_address (r_min_address),
        .i_max_address (r_max_address),
        .o_state       (n_state),
        .o_result      (n_out_item)
    );

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= STATE_RESET;
            r_out_valid   <= 1'b0;
            r_min_address <= 32'h0000_0000;
            r_max_address <= 32'hFFFF_FFFF;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            // Hold the result until taken; refill on every accepted item.
            if (in_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MIN_ADDRESS: r_min_address <= i_cfg_data;
                    REG_MAX_ADDRESS: r_max_address <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result payload: no reset needed, qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

/* hdl/fibp_checker.sv */
`default_nettype none

module fibp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire fibp_pkg::t_in_item  i_in_item,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire fibp_pkg::t_out_item o_out_item
);
    import fibp_pkg::*;

    // A waiting result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Every accepted item shows a result in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item produced no result");

    // A restart is always acknowledged as such.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.command == CMD_RESTART
        |=> o_out_item.kind == KIND_RESTARTED)
        else $error("restart not acknowledged");

    // Input stays open while nothing waits at the output.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output register");

    // Only write results carry a page base.
    a_page_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.page_base != 32'd0
        |-> o_out_item.kind == KIND_WRITE || o_out_item.kind == KIND_ERASE_WRITE)
        else $error("page base on a non-write result");

endmodule

bind firmware_image_block_parser_top fibp_checker u_fibp_checker (.*);

`default_nettype wire

/* dv/firmware_image_block_parser_top_tb.sv */
`timescale 1ns / 1ps

module firmware_image_block_parser_top_tb;

    import fibp_pkg::*;

    localparam int BLOCK_BYTES      = 196;
    localparam int HEADER_BYTES     = 8;
    localparam int PAGE_OFFSET_BITS = 10;

    // Command code with no meaning; the parser answers it as refused.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [31:0] PAGE_MASK   = (32'd1 << PAGE_OFFSET_BITS) - 32'd1;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          MIN_ITEMS   = 700;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_item   = '0;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_MIN_ADDRESS;
    logic [31:0] cfg_data  = '0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    firmware_image_block_parser_top #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .HEADER_BYTES     (HEADER_BYTES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Scoreboard storage
    // ------------------------------------------------------------------
    t_in_item  image_q[$];      // stream items waiting for the driver
    t_out_item result_q[$];     // predicted results, oldest first

    int   mismatches  = 0;
    int   stream_items = 0;
    int   cycles      = 0;
    logic in_taken    = 1'b0;   // an item was accepted at the last rising edge
    logic calm        = 1'b0;   // no idling on either side while set
    int   send_gap    = 0;
    int   stall_left  = 0;

    // Mirror of the configuration registers.
    logic [31:0] cfg_min = 32'h0000_0000;
    logic [31:0] cfg_max = 32'hFFFF_FFFF;

    // Mirror of the parser state.
    t_phase      ps_phase     = PH_HEADER;
    logic [7:0]  ps_count     = '0;
    logic        ps_mismatch  = 1'b0;
    logic [31:0] ps_address   = '0;
    logic [31:0] ps_last_page = '0;
    logic        ps_page_ok   = 1'b0;

    // Generator side: last block address handed out.
    logic [31:0] gen_last_addr = '0;

    function automatic void clear_parser();
        ps_phase     = PH_HEADER;
        ps_count     = '0;
        ps_mismatch  = 1'b0;
        ps_address   = '0;
        ps_last_page = '0;
        ps_page_ok   = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Parser prediction: advance the mirrored state by one item and
    // return the result it produces.
    // ------------------------------------------------------------------
    function automatic t_out_item parse_step(input t_in_item it);
        t_out_item   r;
        logic [7:0]  pos;
        logic [31:0] page;
        r = '0;
        case (it.command)
            CMD_BYTE: begin
                if (ps_phase == PH_HEADER) begin
                    if (it.data_byte != SIGNATURE[ps_count[3:0]])
                        ps_mismatch = 1'b1;
                    ps_count = ps_count + 8'd1;
                    r.kind = KIND_HEADER_BYTE;
                    if (ps_count >= HEADER_BYTES) begin
                        ps_count = '0;
                        if (ps_mismatch) begin
                            ps_phase = PH_ERROR;
                            r.kind   = KIND_BAD_HEADER;
                        end else begin
                            ps_phase = PH_BLOCK;
                        end
                    end
                end else if (ps_phase != PH_BLOCK) begin
                    r.kind = KIND_REFUSED;
                end else begin
                    pos = ps_count;
                    if (pos < 8'd4) begin
                        if (pos == 8'd0)
                            ps_address = '0;
                        ps_address[8*pos +: 8] = it.data_byte;
                    end
                    ps_count = ps_count + 8'd1;
                    if (pos < ADDR_PAD_BYTES) begin
                        r.kind = KIND_ADDR_BYTE;
                    end else begin
                        r.staged_byte   = it.data_byte;
                        r.staged_offset = pos - ADDR_PAD_BYTES;
                        if (ps_count < BLOCK_BYTES) begin
                            r.kind = KIND_DATA_STAGED;
                        end else begin
                            // Block complete: alignment, window, then page tracking.
                            ps_count        = '0;
                            page            = ps_address & ~PAGE_MASK;
                            r.block_address = ps_address;
                            if ((ps_address & ALIGN_MASK) != 0) begin
                                ps_phase = PH_ERROR;
                                r.kind   = KIND_MISALIGNED;
                            end else if (ps_address < cfg_min || ps_address >= cfg_max) begin
                                ps_phase = PH_ERROR;
                                r.kind   = KIND_RANGE;
                            end else begin
                                r.page_base = page;
                                if (!ps_page_ok || page != ps_last_page) begin
                                    ps_last_page = page;
                                    ps_page_ok   = 1'b1;
                                    r.kind       = KIND_ERASE_WRITE;
                                end else begin
                                    r.kind = KIND_WRITE;
                                end
                            end
                        end
                    end
                end
            end
            CMD_EOF: begin
                r.kind = (ps_phase == PH_BLOCK && ps_count == 0) ? KIND_EOF_OK : KIND_EOF_BAD;
            end
            CMD_RESTART: begin
                clear_parser();
                r.kind = KIND_RESTARTED;
            end
            default: begin
                r.kind = KIND_REFUSED;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Idle length: mostly short, now and then long.
    function automatic int draw_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 1;
        else if (r < 80)
            return $urandom_range(2, 4);
        else if (r < 96)
            return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the drained result first (it belongs to an older
    // item), then predict the item taken at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : watch_ports
        t_out_item want;
        t_out_item got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = out_item;
                if (result_q.size() == 0) begin
                    $error("result item with no expectation: kind %0d", got.kind);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("block_address", want.block_address, got.block_address);
                    check_field("page_base", want.page_base, got.page_base);
                    check_field("staged_byte", 32'(want.staged_byte), 32'(got.staged_byte));
                    check_field("staged_offset", 32'(want.staged_offset),
                                32'(got.staged_offset));
                end
            end
            if (in_valid && in_ready) begin
                want = parse_step(in_item);
                result_q.push_back(want);
            end
            in_taken <= in_valid && in_ready;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: drop valid after acceptance, wait out the gap, then
    // present the next pending item. One assignment per signal per edge.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_input
        logic     nv;
        t_in_item ni;
        nv = in_valid;
        ni = in_item;
        if (!rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_taken)
                nv = 1'b0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (image_q.size() > 0) begin
                    ni = image_q.pop_front();
                    nv = 1'b1;
                    send_gap = (calm || $urandom_range(0, 1) == 0) ? 0 : draw_idle_len();
                end
            end
        end
        in_valid <= nv;
        in_item  <= ni;
    end

    // Output side: hold ready low for random stalls, except in calm stretches.
    always @(negedge clk) begin : drive_ready
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0) begin
            rdy = 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = draw_idle_len() - 1;
            rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    // Guard against a hang.
    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] cmd, input logic [7:0] b);
        t_in_item it;
        it.command   = cmd;
        it.data_byte = b;
        image_q.push_back(it);
        stream_items++;
    endtask

    // Hold until every item is sent and every result has been checked.
    task automatic wait_idle();
        while (image_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        if (idx == REG_MIN_ADDRESS)
            cfg_min = value;
        else
            cfg_max = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] draw_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_header(input logic corrupt);
        int         bad_at;
        logic [7:0] b;
        bad_at = $urandom_range(0, HEADER_BYTES - 1);
        for (int i = 0; i < HEADER_BYTES; i++) begin
            b = SIGNATURE[i];
            if (corrupt && i == bad_at)
                b = b ^ 8'($urandom_range(1, 255));
            push_item(CMD_BYTE, b);
        end
    endtask

    // Push len bytes of a block; optionally drop an end of file in the middle.
    task automatic push_block(input logic [31:0] addr, input int len, input logic mid_eof);
        int eof_at;
        eof_at = mid_eof ? $urandom_range(1, BLOCK_BYTES - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == eof_at)
                push_item(CMD_EOF, draw_data());
            if (i < 4)
                push_item(CMD_BYTE, addr[8*i +: 8]);
            else
                push_item(CMD_BYTE, draw_data());
        end
    endtask

    // Pick a block address: mostly legal, some on the same page, some bad.
    function automatic logic [31:0] pick_block_addr();
        logic [31:0] lo;
        logic [31:0] span;
        logic [31:0] a;
        int          r;
        r  = $urandom_range(0, 99);
        lo = (cfg_min + 32'd127) & ~ALIGN_MASK;
        if (r < 6) begin
            a = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FF80 : 32'h0000_0000;
        end else if (r < 16) begin
            a = (gen_last_addr & ~ALIGN_MASK) | 32'($urandom_range(1, 127));
        end else if (r < 26) begin
            a = $urandom & ~ALIGN_MASK;
        end else if (r < 50) begin
            a = (gen_last_addr & ~PAGE_MASK) | ($urandom & PAGE_MASK & ~ALIGN_MASK);
        end else if (lo >= cfg_min && lo < cfg_max) begin
            span = cfg_max - lo;
            a = lo + (($urandom % span) & ~ALIGN_MASK);
        end else begin
            a = $urandom & ~ALIGN_MASK;
        end
        gen_last_addr = a;
        return a;
    endfunction

    task automatic apply_setting(input int k);
        logic [31:0] base;
        case (k)
            0: begin
                write_reg(REG_MIN_ADDRESS, 32'h0000_0000);
                write_reg(REG_MAX_ADDRESS, 32'hFFFF_FFFF);
            end
            1: begin
                write_reg(REG_MIN_ADDRESS, 32'h0000_0000);
                write_reg(REG_MAX_ADDRESS, 32'h0000_0000);
            end
            2: begin
                write_reg(REG_MIN_ADDRESS, 32'hFFFF_FF80);
                write_reg(REG_MAX_ADDRESS, 32'hFFFF_FFFF);
            end
            3: begin
                base = $urandom & ~ALIGN_MASK;
                write_reg(REG_MIN_ADDRESS, base);
                write_reg(REG_MAX_ADDRESS, base + ($urandom_range(1, 64) << PAGE_OFFSET_BITS));
            end
            4: begin
                write_reg(REG_MIN_ADDRESS, 32'hFFFF_FFFF);
                write_reg(REG_MAX_ADDRESS, 32'h0000_0000);
            end
            default: begin
                write_reg(REG_MIN_ADDRESS, $urandom);
                write_reg(REG_MAX_ADDRESS, $urandom);
            end
        endcase
    endtask

    // One well-formed image with random content, sometimes broken.
    task automatic push_image();
        int nblk;
        int len;
        if ($urandom_range(0, 99) >= 15)
            push_item(CMD_RESTART, draw_data());
        push_header($urandom_range(0, 9) == 0);
        nblk = $urandom_range(1, 3);
        for (int n = 0; n < nblk; n++) begin
            // Truncate an occasional last block and restart on top of it.
            len = (n == nblk - 1 && $urandom_range(0, 9) == 0) ?
                  $urandom_range(1, BLOCK_BYTES - 1) : BLOCK_BYTES;
            push_block(pick_block_addr(), len, $urandom_range(0, 9) == 0);
            if (len != BLOCK_BYTES)
                push_item(CMD_RESTART, draw_data());
        end
        push_item(CMD_EOF, draw_data());
        if ($urandom_range(0, 4) == 0)
            push_item(CMD_BYTE, draw_data());
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(20, 80);
        for (int i = 0; i < n; i++)
            push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int round;
        clear_parser();

        // Hold reset, then release it at a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Load both registers with their reset values.
        write_reg(REG_MIN_ADDRESS, 32'h0000_0000);
        write_reg(REG_MAX_ADDRESS, 32'hFFFF_FFFF);

        // Directed: end of file and unused command in each phase, a bad
        // header with the sticky error, then a clean header.
        push_item(CMD_EOF, 8'hA5);
        push_item(CMD_UNUSED, 8'h00);
        push_item(CMD_RESTART, 8'hFF);
        push_item(CMD_BYTE, 8'hFF);
        for (int i = 1; i < HEADER_BYTES; i++)
            push_item(CMD_BYTE, SIGNATURE[i]);
        push_item(CMD_BYTE, 8'h5A);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_UNUSED, 8'hFF);
        push_item(CMD_RESTART, 8'h00);
        push_header(1'b0);
        push_item(CMD_EOF, 8'h00);
        push_item(CMD_UNUSED, 8'h3C);
        wait_idle();

        // Random rounds; the block drains fully between rounds, and the
        // window changes only then. Walk the fixed settings first.
        stream_items = 0;
        round = 0;
        while (stream_items < MIN_ITEMS) begin
            if (round < 6)
                apply_setting(round);
            else if ($urandom_range(0, 2) == 0)
                apply_setting($urandom_range(0, 5));
            calm = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 25)
                push_noise();
            else
                push_image();
            wait_idle();
            round++;
        end

        // Let the pipeline settle after the last result.
        calm = 1'b0;
        repeat (4) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/fibp_pkg.sv
hdl/fibp_step.sv
hdl/firmware_image_block_parser_top.sv
hdl/fibp_checker.sv
dv/firmware_image_block_parser_top_tb.sv
